// ===== rtl/btpc_pkg.sv =====
// btpc_pkg: shared types and constants for the barometric compensation block
// no dependencies
package btpc_pkg;
  localparam int unsigned RawW = 20;
  localparam logic [1:0] REG_CAL_T  = 2'd0;
  localparam logic [1:0] REG_CAL_PL = 2'd1;
  localparam logic [1:0] REG_CAL_PH = 2'd2;
  localparam logic [1:0] REG_CAL_P9 = 2'd3;

  typedef struct packed {
    logic [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
  } cal_t_t;

  typedef struct packed {
    logic [15:0] p1;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
  } cal_p_t;

  typedef struct packed {
    logic [RawW-1:0] raw_temperature;
    logic [RawW-1:0] raw_pressure;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] temperature_centi;
    logic [17:0] pressure_pa;
    logic signed [31:0] fine_temperature;
    logic pressure_invalid;
  } out_word_t;
endpackage

// ===== rtl/btpc_if.sv =====
// btpc_if: valid/ready channel carrying one payload word
// depends on nothing; payload type set by parameter
interface btpc_if #(parameter type word_t = logic) ();
  logic valid;
  logic ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/btpc_cfg_if.sv =====
// btpc_cfg_if: configuration write channel
// depends on nothing
interface btpc_cfg_if ();
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [63:0] value;
  modport source (output valid, output index, output value, input ready);
  modport sink (input valid, input index, input value, output ready);
endinterface

// ===== rtl/baro_temp_pressure_compensation.sv =====
// baro_temp_pressure_compensation: pipelined temperature and pressure compensation
// depends on btpc_pkg, btpc_if, btpc_cfg_if
// pipeline: 80 register stages (mults, 64 radix-2 divider stages)
// throughput: one word per cycle; the whole pipe advances only when the output
//   stage is free or being taken, so a stall holds every stage in place
// reset: rst clears calibration registers and all valid bits; payload is not reset
module baro_temp_pressure_compensation (
  input logic clk,
  input logic rst,
  btpc_cfg_if.sink cfg,
  btpc_if.sink in_ch,
  btpc_if.source out_ch
);
  import btpc_pkg::*;

  localparam int N = 80;

  cal_t_t ct;
  cal_p_t cp;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ct <= '0;
      cp <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_CAL_T:  ct <= {cfg.value[15:0], cfg.value[31:16], cfg.value[47:32]};
        REG_CAL_PL: {cp.p4, cp.p3, cp.p2, cp.p1} <= cfg.value;
        REG_CAL_PH: {cp.p8, cp.p7, cp.p6, cp.p5} <= cfg.value;
        REG_CAL_P9: cp.p9 <= cfg.value[15:0];
        default: ;
      endcase
    end
  end

  // global advance: the pipe moves as a whole
  logic adv;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  logic [N-1:0] v;
  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else if (adv) v <= {v[N-2:0], in_ch.valid};
  end
  assign out_ch.valid = v[N-1];

  // ---------------- temperature path (stages 1..4) ----------------
  logic [31:0] s1_d1, s1_d2;
  logic [19:0] rp1;
  logic [31:0] s2_a1m, s2_sq;
  logic [19:0] rp2;
  logic [31:0] s3_a1, s3_t3m;
  logic [19:0] rp3;
  logic [31:0] fine4;
  logic [19:0] rp4;
  always_ff @(posedge clk) if (adv) begin
    s1_d1 <= {15'd0, in_ch.data.raw_temperature[19:3]} - {15'd0, ct.t1, 1'b0};
    s1_d2 <= {16'd0, in_ch.data.raw_temperature[19:4]} - {16'd0, ct.t1};
    rp1 <= in_ch.data.raw_pressure;
    s2_a1m <= s1_d1 * {{16{ct.t2[15]}}, ct.t2};
    s2_sq <= s1_d2 * s1_d2;
    rp2 <= rp1;
    s3_a1 <= 32'($signed(s2_a1m) >>> 11);
    s3_t3m <= 32'($signed(s2_sq) >>> 12) * {{16{ct.t3[15]}}, ct.t3};
    rp3 <= rp2;
    fine4 <= s3_a1 + 32'($signed(s3_t3m) >>> 14);
    rp4 <= rp3;
  end

  // temperature output computed at stage 5 and delayed alongside
  logic signed [31:0] tc;
  logic [15:0] tsat;
  always_comb begin
    tc = $signed(fine4 * 32'd5 + 32'd128) >>> 8;
    if (tc < -32768) tsat = 16'h8000;
    else if (tc > 32767) tsat = 16'h7FFF;
    else tsat = tc[15:0];
  end

  // ---------------- pressure prep (stages 5..10) ----------------
  logic [63:0] v1_5;
  logic [19:0] rp5;
  logic [63:0] sq6, p5m6, p2m6;
  logic [19:0] rp6;
  logic [63:0] q7a, q7b, q7c, q7d;
  logic [19:0] rp7;
  logic [63:0] v2_8, v1s_8;
  logic [19:0] rp8;
  logic [63:0] v1m_9, v2_9;
  logic [19:0] rp9;
  logic [63:0] v1_10;
  logic [63:0] v2_10;
  logic [19:0] rp10;

  // v1 fits in 33 bits signed, so its square needs only a 33x33 product
  logic signed [65:0] v1sq;
  assign v1sq = $signed(v1_5[32:0]) * $signed(v1_5[32:0]);

  // temperature-side sideband through the whole pipe
  logic [15:0] tq [5:N-1];
  logic [31:0] fq [5:N-1];

  always_ff @(posedge clk) if (adv) begin
    tq[5] <= tsat;
    fq[5] <= fine4;
    for (int i = 6; i < N; i++) begin
      tq[i] <= tq[i-1];
      fq[i] <= fq[i-1];
    end
    v1_5 <= {{32{fine4[31]}}, fine4} - 64'd128000;
    rp5 <= rp4;
    sq6 <= v1sq[63:0];
    p5m6 <= v1_5 * {{48{cp.p5[15]}}, cp.p5};
    p2m6 <= v1_5 * {{48{cp.p2[15]}}, cp.p2};
    rp6 <= rp5;
    q7a <= sq6 * {{48{cp.p6[15]}}, cp.p6};
    q7b <= sq6 * {{48{cp.p3[15]}}, cp.p3};
    q7c <= p5m6;
    q7d <= p2m6;
    rp7 <= rp6;
    v2_8 <= q7a + (q7c << 17) + ({{48{cp.p4[15]}}, cp.p4} << 35);
    v1s_8 <= 64'($signed(q7b) >>> 8) + (q7d << 12);
    rp8 <= rp7;
    v1m_9 <= ((64'd1 << 47) + v1s_8) * {48'd0, cp.p1};
    v2_9 <= v2_8;
    rp9 <= rp8;
    v1_10 <= 64'($signed(v1m_9) >>> 33);
    v2_10 <= v2_9;
    rp10 <= rp9;
  end

  // numerator at stage 11
  logic [63:0] n11, d11;
  always_ff @(posedge clk) if (adv) begin
    n11 <= ((({43'd0, 21'(21'd1048576 - {1'b0, rp10})} ) << 31) - v2_10) * 64'd3125;
    d11 <= v1_10;
  end

  // ---------------- radix-2 restoring divider, 64 stages (13..76) ----------------
  localparam int DS = 12;
  logic [63:0] dq [DS:DS+64];
  logic [63:0] dr [DS:DS+64];
  logic [63:0] dd [DS:DS+64];
  logic dneg [DS:DS+64];
  logic dz [DS:DS+64];

  always_ff @(posedge clk) if (adv) begin
    dq[DS] <= n11[63] ? -n11 : n11;
    dr[DS] <= '0;
    dd[DS] <= d11[63] ? -d11 : d11;
    dneg[DS] <= n11[63] ^ d11[63];
    dz[DS] <= (d11 == 64'd0);
  end

  for (genvar k = DS; k < DS + 64; k++) begin : g_div
    logic [64:0] rsh;
    logic [64:0] dif;
    assign rsh = {dr[k], dq[k][63]};
    assign dif = rsh - {1'b0, dd[k]};
    always_ff @(posedge clk) if (adv) begin
      dq[k+1] <= {dq[k][62:0], !dif[64]};
      dr[k+1] <= dif[64] ? rsh[63:0] : dif[63:0];
      dd[k+1] <= dd[k];
      dneg[k+1] <= dneg[k];
      dz[k+1] <= dz[k];
    end
  end
  // stage 77: signed quotient; 78: square and p8 term; 79: p9 term and partial sum
  localparam int QS = DS + 64;
  logic [63:0] p77, ps77;
  logic z77, z78, z79;
  logic [63:0] w2_78, p78;
  logic [63:0] psq78;
  logic [63:0] w1_79, sum79;

  // low 64 bits of ps squared from 32-bit halves
  logic [63:0] sq_ll;
  logic [31:0] sq_hl;
  assign sq_ll = {32'd0, ps77[31:0]} * {32'd0, ps77[31:0]};
  assign sq_hl = ps77[63:32] * ps77[31:0];

  always_ff @(posedge clk) if (adv) begin
    p77 <= dneg[QS] ? -dq[QS] : dq[QS];
    ps77 <= 64'($signed(dneg[QS] ? -dq[QS] : dq[QS]) >>> 13);
    z77 <= dz[QS];
    psq78 <= sq_ll + {sq_hl[30:0], 33'd0};
    w2_78 <= 64'($signed(p77 * {{48{cp.p8[15]}}, cp.p8}) >>> 19);
    p78 <= p77;
    z78 <= z77;
    w1_79 <= 64'($signed(psq78 * {{48{cp.p9[15]}}, cp.p9}) >>> 25);
    sum79 <= p78 + w2_78;
    z79 <= z78;
  end

  // final stage (register at index N-1 = 79 via out registers)
  logic [63:0] pf;
  logic [17:0] pa;
  always_comb begin
    pf = 64'($signed(sum79 + w1_79) >>> 8) + ({{48{cp.p7[15]}}, cp.p7} << 4);
    if (z79 || pf[63]) pa = '0;
    else if (pf[63:8] > 56'd262143) pa = 18'h3FFFF;
    else pa = pf[25:8];
  end

  out_word_t ow;
  always_ff @(posedge clk) if (adv) begin
    ow.temperature_centi <= tq[N-1];
    ow.fine_temperature <= fq[N-1];
    ow.pressure_pa <= pa;
    ow.pressure_invalid <= z79;
  end
  assign out_ch.data = ow;
endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for baro_temp_pressure_compensation
// depends on btpc_pkg, btpc_if, btpc_cfg_if and the compensation block itself
// directed and random stimulus across several calibration sets, checked against an in-bench predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import btpc_pkg::*;

  localparam int unsigned PressMax = 262143;
  localparam int unsigned PipeDrain = 100;   // idle cycles after the owed results have come back
  localparam int unsigned QuietLimit = 5000; // cycles with no handshake at all
  localparam int unsigned MaxShown = 10;

  // typical factory calibration halfwords
  localparam logic [15:0] TypT1 = 16'd27504;
  localparam logic [15:0] TypT2 = 16'd26435;
  localparam logic [15:0] TypT3 = -16'sd1000;
  localparam logic [15:0] TypP1 = 16'd36477;
  localparam logic [15:0] TypP2 = -16'sd10685;
  localparam logic [15:0] TypP3 = 16'd3024;
  localparam logic [15:0] TypP4 = 16'd2855;
  localparam logic [15:0] TypP5 = 16'd140;
  localparam logic [15:0] TypP6 = -16'sd7;
  localparam logic [15:0] TypP7 = 16'd15500;
  localparam logic [15:0] TypP8 = -16'sd14600;
  localparam logic [15:0] TypP9 = 16'd6000;

  // compensation predictor plus a queue of results still owed by the block
  class compensation_sb;
    bit [47:0] cal_t;
    bit [63:0] cal_pl;
    bit [63:0] cal_ph;
    bit [15:0] cal_p9;
    out_word_t owed[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned invalid_seen;
    int unsigned sat_seen;

    function void write_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        REG_CAL_T: cal_t = val[47:0];
        REG_CAL_PL: cal_pl = val;
        REG_CAL_PH: cal_ph = val;
        REG_CAL_P9: cal_p9 = val[15:0];
        default: ;
      endcase
    endfunction

    static function bit [63:0] sx16(bit [15:0] h);
      return {{48{h[15]}}, h};
    endfunction

    static function bit [31:0] asr32(bit [31:0] x, int n);
      return $signed(x) >>> n;
    endfunction

    static function bit [63:0] asr64(bit [63:0] x, int n);
      return $signed(x) >>> n;
    endfunction

    // signed divide truncating toward zero, most negative / -1 wraps
    static function bit [63:0] sdiv64(bit [63:0] num, bit [63:0] den);
      bit [63:0] a;
      bit [63:0] b;
      bit [63:0] q;
      a = num[63] ? -num : num;
      b = den[63] ? -den : den;
      q = a / b;
      return (num[63] != den[63]) ? -q : q;
    endfunction

    function out_word_t predict(in_word_t s);
      bit [31:0] rt, t1, t2, t3, d1, a1, d2, a2, fine, tc;
      bit [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      bit [63:0] v1, v2, p, ps, w1, w2, pa;
      out_word_t r;
      rt = 32'(s.raw_temperature);
      t1 = {16'b0, cal_t[15:0]};
      t2 = {{16{cal_t[31]}}, cal_t[31:16]};
      t3 = {{16{cal_t[47]}}, cal_t[47:32]};
      p1 = {48'b0, cal_pl[15:0]};
      p2 = sx16(cal_pl[31:16]);
      p3 = sx16(cal_pl[47:32]);
      p4 = sx16(cal_pl[63:48]);
      p5 = sx16(cal_ph[15:0]);
      p6 = sx16(cal_ph[31:16]);
      p7 = sx16(cal_ph[47:32]);
      p8 = sx16(cal_ph[63:48]);
      p9 = sx16(cal_p9);
      // temperature path wraps at 32 bits
      d1 = (rt >> 3) - (t1 << 1);
      a1 = asr32(d1 * t2, 11);
      d2 = (rt >> 4) - t1;
      a2 = asr32(asr32(d2 * d2, 12) * t3, 14);
      fine = a1 + a2;
      tc = asr32(fine * 32'd5 + 32'd128, 8);
      if ($signed(tc) < -32768) r.temperature_centi = 16'h8000;
      else if ($signed(tc) > 32767) r.temperature_centi = 16'h7FFF;
      else r.temperature_centi = tc[15:0];
      r.fine_temperature = fine;
      // pressure path wraps at 64 bits
      v1 = {{32{fine[31]}}, fine} - 64'd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) << 17);
      v2 = v2 + (p4 << 35);
      v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
      v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
      pa = 0;
      r.pressure_invalid = 1'b0;
      if (v1 == 0) begin
        r.pressure_invalid = 1'b1;
      end else begin
        p = 64'd1048576 - 64'(s.raw_pressure);
        p = sdiv64(((p << 31) - v2) * 64'd3125, v1);
        ps = asr64(p, 13);
        w1 = asr64(p9 * ps * ps, 25);
        w2 = asr64(p8 * p, 19);
        p = asr64(p + w1 + w2, 8) + (p7 << 4);
        if (!p[63]) begin
          pa = p >> 8;
          if (pa > PressMax) pa = PressMax;
        end
      end
      r.pressure_pa = pa[17:0];
      return r;
    endfunction

    function void note_sample(in_word_t s);
      owed.push_back(predict(s));
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_w;
      bit bad;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("error: unexpected result word %h", got);
        return;
      end
      exp_w = owed.pop_front();
      checked++;
      if (exp_w.pressure_invalid) invalid_seen++;
      if (exp_w.pressure_pa == PressMax || exp_w.temperature_centi == 16'h7FFF ||
          exp_w.temperature_centi == 16'h8000) sat_seen++;
      bad = (got.temperature_centi !== exp_w.temperature_centi) ||
            (got.pressure_pa !== exp_w.pressure_pa) ||
            (got.fine_temperature !== exp_w.fine_temperature) ||
            (got.pressure_invalid !== exp_w.pressure_invalid);
      if (bad) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("error: result %0d exp t=%0d p=%0d f=%0d inv=%0b got t=%0d p=%0d f=%0d inv=%0b",
                   checked, exp_w.temperature_centi, exp_w.pressure_pa,
                   exp_w.fine_temperature, exp_w.pressure_invalid,
                   got.temperature_centi, got.pressure_pa,
                   got.fine_temperature, got.pressure_invalid);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  btpc_cfg_if cfg_ch ();
  btpc_if #(.word_t(in_word_t)) in_ch ();
  btpc_if #(.word_t(out_word_t)) out_ch ();

  baro_temp_pressure_compensation dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch.sink),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  compensation_sb sb;
  bit idle_on;
  int unsigned sink_stall;
  int unsigned quiet_cycles;
  int unsigned samples_sent;
  int unsigned cfg_writes;

  // 8 ns clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // result side: random stall bursts while idling is on
  always @(negedge clk) begin
    if (!idle_on) begin
      out_ch.ready <= 1'b1;
    end else if (sink_stall > 0) begin
      sink_stall--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      sink_stall = $urandom_range(1, 5) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // handshake monitor: every accepted word goes to the scoreboard
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        sb.write_reg(cfg_ch.index, cfg_ch.value);
        cfg_writes++;
      end
      if (in_ch.valid && in_ch.ready) sb.note_sample(in_ch.data);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
      // watchdog on handshake activity
      if ((cfg_ch.valid && cfg_ch.ready) || (in_ch.valid && in_ch.ready) ||
          (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("timeout: no handshake for %0d cycles", quiet_cycles);
          $display("FAIL baro_temp_pressure_compensation");
          $finish;
        end
      end
    end
  end

  // one calibration register write, block must be idle; valid stays up for the next one
  task automatic write_cal(logic [1:0] idx, logic [63:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.value <= val;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    @(negedge clk);
  endtask

  task automatic write_all_cal(logic [47:0] ct, logic [63:0] pl, logic [63:0] ph,
                               logic [15:0] p9);
    write_cal(REG_CAL_T, {16'b0, ct});
    write_cal(REG_CAL_PL, pl);
    write_cal(REG_CAL_PH, ph);
    write_cal(REG_CAL_P9, {48'b0, p9});
    cfg_ch.valid <= 1'b0;
  endtask

  // let every owed result come back, then let the pipe run empty
  task automatic drain_pipe();
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (PipeDrain) @(negedge clk);
  endtask

  // one sample word, with an optional idle burst in front
  task automatic send_sample(logic [19:0] rt, logic [19:0] rp);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= '{raw_temperature: rt, raw_pressure: rp};
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
    samples_sent++;
  endtask

  task automatic stop_samples();
    in_ch.valid <= 1'b0;
  endtask

  // half the time a plausible conversion value, otherwise anywhere in 20 bits
  function automatic logic [19:0] pick_raw(int unsigned lo, int unsigned hi);
    if ($urandom_range(0, 1) == 0) return 20'($urandom_range(lo, hi));
    return 20'($urandom);
  endfunction

  function automatic logic [15:0] nudge(logic [15:0] h);
    return h + 16'($urandom_range(0, 200)) - 16'd100;
  endfunction

  initial begin
    logic [47:0] ct;
    logic [63:0] pl;
    logic [63:0] ph;
    logic [15:0] p9;
    int unsigned mode;
    sb = new();
    idle_on = 1'b0;
    sink_stall = 0;
    quiet_cycles = 0;
    samples_sent = 0;
    cfg_writes = 0;
    rst = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_CAL_T;
    cfg_ch.value = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b1;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // calibration still zero after reset: divisor is zero, invalid pressure
    send_sample(20'd0, 20'd0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'd519888, 20'd415148);
    stop_samples();
    drain_pipe();

    // typical calibration with raw extremes and a known sample point
    write_all_cal({TypT3, TypT2, TypT1}, {TypP4, TypP3, TypP2, TypP1},
                  {TypP8, TypP7, TypP6, TypP5}, TypP9);
    send_sample(20'd519888, 20'd415148);
    send_sample(20'd0, 20'd0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'd0, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'd0);
    send_sample(20'h55555, 20'hAAAAA);
    send_sample(20'hAAAAA, 20'h55555);
    send_sample(20'd440000, 20'd300000);
    stop_samples();
    drain_pipe();

    // extreme calibration: all ones, then signed halfwords at their bottom, then at their top
    write_all_cal({48{1'b1}}, {64{1'b1}}, {64{1'b1}}, 16'hFFFF);
    send_sample(20'd0, 20'd0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'd519888, 20'd415148);
    stop_samples();
    drain_pipe();
    write_all_cal({16'h8000, 16'h8000, 16'hFFFF}, {{3{16'h8000}}, 16'hFFFF},
                  {4{16'h8000}}, 16'h8000);
    send_sample(20'd0, 20'd0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'd519888, 20'd415148);
    stop_samples();
    drain_pipe();
    write_all_cal({16'h7FFF, 16'h7FFF, 16'h0000}, {{3{16'h7FFF}}, 16'h0001},
                  {4{16'h7FFF}}, 16'h7FFF);
    send_sample(20'd0, 20'd0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    stop_samples();
    drain_pipe();

    // random phases: nudged typical sets, fully random sets, idling mostly on
    for (int ph_i = 0; ph_i < 7; ph_i++) begin
      mode = $urandom_range(0, 2);
      if (ph_i == 0 || mode != 0) begin
        ct = {nudge(TypT3), nudge(TypT2), nudge(TypT1)};
        pl = {nudge(TypP4), nudge(TypP3), nudge(TypP2), nudge(TypP1)};
        ph = {nudge(TypP8), nudge(TypP7), nudge(TypP6), nudge(TypP5)};
        p9 = nudge(TypP9);
      end else begin
        ct = 48'({$urandom, $urandom});
        pl = {$urandom, $urandom};
        ph = {$urandom, $urandom};
        p9 = 16'($urandom);
      end
      write_all_cal(ct, pl, ph, p9);
      // phase 3 and the last phase run without any idling
      idle_on = (ph_i < 6) && (ph_i != 3);
      for (int k = 0; k < 220; k++)
        send_sample(pick_raw(400000, 620000), pick_raw(200000, 500000));
      stop_samples();
      drain_pipe();
    end

    $display("ran %0d samples over %0d calibration writes: %0d invalid, %0d saturated",
             samples_sent, cfg_writes, sb.invalid_seen, sb.sat_seen);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("PASS baro_temp_pressure_compensation");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.owed.size());
      $display("FAIL baro_temp_pressure_compensation");
    end
    $finish;
  end
endmodule

// ===== baro_temp_pressure_compensation.f =====
rtl/btpc_pkg.sv
rtl/btpc_if.sv
rtl/btpc_cfg_if.sv
rtl/baro_temp_pressure_compensation.sv
tb/tb_top.sv
